/* src/gto_pkg.sv */
// graph traversal order package: payload structs, register indexes, sequencer states
// and size defaults shared by the core
// no dependencies
package gto_pkg;

   localparam int NODE_W            = 5;
   localparam int ROW_W             = 32;
   localparam int LABEL_W           = 8;
   localparam int COUNT_W           = 6;
   localparam int CSR_DATA_W        = 6;
   localparam int CSR_ADDR_W        = 1;
   localparam int MAX_NODES_DEF     = 32;
   localparam int PENDING_DEPTH_DEF = 1024;

   localparam logic [CSR_ADDR_W-1:0] CSR_NODE_COUNT = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WALK_MODE  = 1'b1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_START = 1'b1;

   localparam logic MODE_DEPTH   = 1'b0;
   localparam logic MODE_BREADTH = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [NODE_W-1:0]  node;
      logic [ROW_W-1:0]   row_bits;
      logic [LABEL_W-1:0] label;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]  visited_node;
      logic [LABEL_W-1:0] visited_label;
      logic               last;
      logic               empty_graph;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_CHECK,
      ST_VISIT,
      ST_SCAN,
      ST_FINISH,
      ST_EMPTY
   } state_type;

endpackage

/* src/graph_traversal_order_core.sv */
// graph traversal order core: adjacency row store and depth or breadth first walker
// depends on gto_pkg
//
// sequence: a load beat writes its row and label; a start beat pops each pending entry,
//    then scans the row of each visited node over n bits, with n the effective node
//    count, then finds the store empty and sends the final beat; output stalls can hold
//    it; an empty graph start sends one empty beat, an out of range start stays idle
// throughput: one item at a time, the sequencer scans one row bit per cycle
// reset: synchronous, active high; clears control, config and visited map,
//    row, label and pending stores hold anything until written
module graph_traversal_order_core #(
   parameter int MAX_NODES     = gto_pkg::MAX_NODES_DEF,
   parameter int PENDING_DEPTH = gto_pkg::PENDING_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gto_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gto_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [gto_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gto_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gto_pkg::*;

   // rows actually stored, never more than one row word wide
   localparam int ROWS   = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
   localparam int ROW_IW = $clog2(ROWS);
   localparam int PIW    = $clog2(PENDING_DEPTH);
   localparam int PCW    = $clog2(PENDING_DEPTH + 1);

   // storage
   logic [ROW_W-1:0]   adj_mem   [ROWS];
   logic [LABEL_W-1:0] label_mem [ROWS];
   logic [NODE_W-1:0]  pend_mem  [PENDING_DEPTH];

   // registers
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] node_count_ff;
   logic               walk_mode_ff;
   logic [PCW-1:0]     head_ff, head_in;
   logic [PCW-1:0]     tail_ff, tail_in;
   logic [ROWS-1:0]    visited_ff, visited_in;
   logic [NODE_W-1:0]  scan_ff, scan_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic               held_valid_ff, held_valid_in;
   logic [NODE_W-1:0]  held_node_ff, held_node_in;
   logic [LABEL_W-1:0] held_label_ff, held_label_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [NODE_W-1:0]  pend_rd_ff;
   logic [ROW_W-1:0]   adj_rd_ff;
   logic [LABEL_W-1:0] label_rd_ff;

   // datapath controls
   logic               pend_we, pend_re;
   logic [PIW-1:0]     pend_wa, pend_ra;
   logic [NODE_W-1:0]  pend_wd;
   logic               node_re;
   logic               out_load;
   rsp_type            out_data;

   // shared conditions
   logic               req_acc;
   logic               out_free;
   logic [COUNT_W-1:0] n_eff;
   logic               start_ok;
   logic               pop_empty;
   logic               skip;
   logic               scan_last;
   logic               pend_room;
   logic               load_ok;
   logic [PCW-1:0]     tail_dec;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // node count saturates at the stored row count
   assign n_eff = (node_count_ff > COUNT_W'(ROWS)) ? COUNT_W'(ROWS) : node_count_ff;

   assign load_ok   = ({1'b0, req_data.node} < COUNT_W'(ROWS));
   assign start_ok  = ({1'b0, req_data.node} < n_eff);
   assign tail_dec  = tail_ff - PCW'(1);
   assign pop_empty = (walk_mode_ff == MODE_DEPTH) ? (tail_ff == '0) : (head_ff >= tail_ff);
   // out of range or already seen pops are dropped
   assign skip      = ({1'b0, pend_rd_ff} >= n_eff) || visited_ff[pend_rd_ff[ROW_IW-1:0]];
   assign scan_last = ({1'b0, scan_ff} == COUNT_W'(n_eff - 1'b1));
   assign pend_room = (tail_ff < PCW'(PENDING_DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.kind == KIND_START) begin
               if (n_eff == '0) begin
                  state_in = ST_EMPTY;
               end else if (start_ok) begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP:    state_in = pop_empty ? ST_FINISH : ST_CHECK;
         ST_CHECK:  state_in = skip ? ST_POP : ST_VISIT;
         ST_VISIT: begin
            if (!held_valid_ff || out_free) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN:   state_in = scan_last ? ST_POP : ST_SCAN;
         ST_FINISH: begin
            if (!held_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath controls and register next values
   always_comb begin
      pend_we       = 1'b0;
      pend_wa       = '0;
      pend_wd       = '0;
      pend_re       = 1'b0;
      pend_ra       = '0;
      node_re       = 1'b0;
      out_load      = 1'b0;
      out_data      = '0;
      head_in       = head_ff;
      tail_in       = tail_ff;
      visited_in    = visited_ff;
      scan_in       = scan_ff;
      cur_in        = cur_ff;
      held_valid_in = held_valid_ff;
      held_node_in  = held_node_ff;
      held_label_in = held_label_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.kind == KIND_START) begin
               // fresh walk: clear the map, seed the pending store with the start node
               visited_in    = '0;
               head_in       = '0;
               tail_in       = '0;
               held_valid_in = 1'b0;
               if (n_eff != '0 && start_ok) begin
                  pend_we = 1'b1;
                  pend_wa = '0;
                  pend_wd = req_data.node;
                  tail_in = PCW'(1);
               end
            end
         end
         ST_POP: begin
            if (!pop_empty) begin
               pend_re = 1'b1;
               if (walk_mode_ff == MODE_DEPTH) begin
                  pend_ra = tail_dec[PIW-1:0];
                  tail_in = tail_dec;
               end else begin
                  pend_ra = head_ff[PIW-1:0];
                  head_in = head_ff + PCW'(1);
               end
            end
         end
         ST_CHECK: begin
            if (!skip) begin
               node_re = 1'b1;
               cur_in  = pend_rd_ff;
               visited_in[pend_rd_ff[ROW_IW-1:0]] = 1'b1;
            end
         end
         ST_VISIT: begin
            if (!held_valid_ff || out_free) begin
               // the previous visit is known not to be final, send it on
               if (held_valid_ff) begin
                  out_load                = 1'b1;
                  out_data.visited_node   = held_node_ff;
                  out_data.visited_label  = held_label_ff;
               end
               held_valid_in = 1'b1;
               held_node_in  = cur_ff;
               held_label_in = label_rd_ff;
               scan_in       = '0;
            end
         end
         ST_SCAN: begin
            if (adj_rd_ff[scan_ff] && pend_room) begin
               pend_we = 1'b1;
               pend_wa = tail_ff[PIW-1:0];
               pend_wd = scan_ff;
               tail_in = tail_ff + PCW'(1);
            end
            scan_in = scan_ff + NODE_W'(1);
         end
         ST_FINISH: begin
            if (held_valid_ff && out_free) begin
               out_load               = 1'b1;
               out_data.visited_node  = held_node_ff;
               out_data.visited_label = held_label_ff;
               out_data.last          = 1'b1;
               held_valid_in          = 1'b0;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               out_load             = 1'b1;
               out_data.last        = 1'b1;
               out_data.empty_graph = 1'b1;
            end
         end
         default: begin
            held_valid_in = 1'b0;
         end
      endcase
   end

   // output register: takes a new beat once the current one is gone
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = out_load ? out_data : rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= '0;
         walk_mode_ff  <= MODE_DEPTH;
         head_ff       <= '0;
         tail_ff       <= '0;
         visited_ff    <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         visited_ff    <= visited_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_NODE_COUNT: node_count_ff <= csr_wdata[COUNT_W-1:0];
               CSR_WALK_MODE:  walk_mode_ff  <= csr_wdata[0];
               default:        ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cur_ff        <= cur_in;
      held_node_ff  <= held_node_in;
      held_label_ff <= held_label_in;
      rsp_ff        <= rsp_in;
   end

   // row and label stores, written by load beats, read through output registers
   always_ff @(posedge clock) begin
      if (req_acc && req_data.kind == KIND_LOAD && load_ok) begin
         adj_mem[req_data.node[ROW_IW-1:0]]   <= req_data.row_bits;
         label_mem[req_data.node[ROW_IW-1:0]] <= req_data.label;
      end
      if (node_re) begin
         adj_rd_ff   <= adj_mem[pend_rd_ff[ROW_IW-1:0]];
         label_rd_ff <= label_mem[pend_rd_ff[ROW_IW-1:0]];
      end
   end

   // pending store, stack or queue by walk mode
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_wa] <= pend_wd;
      end
      if (pend_re) begin
         pend_rd_ff <= pend_mem[pend_ra];
      end
   end

endmodule
